>>> rtl/ddcg_pkg.sv
// Shared types, constants and a helper function for the differential drive command gate.
package ddcg_pkg;

  localparam int HT_FRAC   = 12;
  localparam int HT_W      = 12;
  localparam int GAIN_W    = 8;
  localparam int OFS_W     = 7;
  localparam int TMO_W     = 16;
  localparam int ELAPSED_W = 17;
  localparam int SPEED_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam int COMP_W  = SPEED_W + HT_W;
  localparam int WHEEL_W = COMP_W + 1;
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 12;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [7:0] PCT_LIMIT = 8'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PERCENT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_PERCENT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 8'd3;

  localparam logic ACT_CMD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [2:0] CAUSE_NONE  = 3'd0;
  localparam logic [2:0] CAUSE_ESTOP = 3'd1;
  localparam logic [2:0] CAUSE_FRONT = 3'd2;
  localparam logic [2:0] CAUSE_REAR  = 3'd3;
  localparam logic [2:0] CAUSE_TMO   = 3'd4;

  typedef struct packed {
    logic                      action;
    logic signed [SPEED_W-1:0] linear_speed;
    logic signed [SPEED_W-1:0] angular_speed;
    logic                      estop;
    logic                      front_contact;
    logic                      rear_contact;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic signed [7:0] left_percent;
    logic signed [7:0] right_percent;
    logic [2:0]        block_cause;
  } out_item_t;

  typedef struct packed {
    logic                      load;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } mul_req_t;

  // (p + 100) * 127 / 100 - 127; the divide by 100 is a reciprocal multiply,
  // exact for the 0..25400 range seen here.
  function automatic logic signed [7:0] map_drive(input logic signed [7:0] p);
    logic [7:0]  q;
    logic [14:0] t;
    logic [27:0] r;
    q = 8'(p + 8'sd100);
    t = {q, 7'b0} - {7'b0, q};
    r = {13'b0, t} * 28'd5243;
    return 8'(r[26:19]) - 8'sd127;
  endfunction

endpackage

>>> rtl/ddcg_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module ddcg_mul
  import ddcg_pkg::*;
(
  input  logic                      clk,
  input  mul_req_t                  req,
  output logic signed [MUL_P_W-1:0] prod
);

  logic signed [MUL_P_W:0] full;

  assign full = req.a * $signed({1'b0, req.b});

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= full[MUL_P_W-1:0];
    end
  end

endmodule

>>> rtl/differential_drive_command_gate.sv
// Top level of the differential drive command gate: sequencer, state and output register.
//
// Input channel in_valid/in_ready/in_data carries one item: a velocity command
// (action 0) or a one millisecond tick (action 1) with estop and bumper flags.
// Output channel out_valid/out_ready/out_data returns one item per input item:
// gated wheel percents, their -127..127 drive values and the block cause.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
// always high and indexes beyond the register list are dropped.
// A command steps through COMP, WHEEL, MULL, MULR, PCTR, GATE and EMIT; one
// shared multiplier is used three times (turn compensation, then left and right
// gain), the wheel sum lies between the first two uses and the left percent is
// taken while the right gain is multiplied. Tick and estop items skip the
// multiplier and pass through GATE and EMIT only. in_ready is high only while
// the sequencer is idle, so no new item is taken until the last has left EMIT.
// A finished item waits in the output register while the next item is taken;
// if the receiver stalls with a result still held, the sequencer holds its
// last step until the register frees.
// Synchronous reset restores register defaults, clears both targets and sets
// the millisecond count saturated, so the drive reads as timed out.
module differential_drive_command_gate
  import ddcg_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int SHIFT = FRAC_BITS + HT_FRAC;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COMP  = 3'd1;
  localparam logic [2:0] S_WHEEL = 3'd2;
  localparam logic [2:0] S_MULL  = 3'd3;
  localparam logic [2:0] S_MULR  = 3'd4;
  localparam logic [2:0] S_PCTR  = 3'd5;
  localparam logic [2:0] S_GATE  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [HT_W-1:0]   half_track;
  logic [GAIN_W-1:0] gain_percent;
  logic [OFS_W-1:0]  offset_percent;
  logic [TMO_W-1:0]  timeout_ms;

  in_item_t                  item;
  logic signed [7:0]         left_target;
  logic signed [7:0]         right_target;
  logic [ELAPSED_W-1:0]      elapsed_ms;
  logic [ELAPSED_W-1:0]      elapsed_next;
  logic signed [WHEEL_W-1:0] wheel_l;
  logic signed [WHEEL_W-1:0] wheel_r;
  logic signed [7:0]         gate_l;
  logic signed [7:0]         gate_r;
  logic [2:0]                gate_cause;

  mul_req_t                  mreq;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [COMP_W-1:0]  base;
  logic signed [COMP_W-1:0]  comp;
  logic signed [7:0]         tgt_l;
  logic signed [7:0]         tgt_r;
  logic [2:0]                cause;
  logic                      out_free;

  function automatic logic [MUL_A_W-1:0] wheel_mag(input logic signed [WHEEL_W-1:0] w);
    logic [WHEEL_W-1:0] m;
    m = w[WHEEL_W-1] ? WHEEL_W'(-w) : WHEEL_W'(w);
    return MUL_A_W'(m);
  endfunction

  function automatic logic signed [7:0] wheel_pct(input logic signed [MUL_P_W-1:0] p,
                                                  input logic signed [WHEEL_W-1:0] w,
                                                  input logic [OFS_W-1:0] ofs);
    logic [MUL_P_W-1:0] scaled;
    logic [7:0]         sum;
    logic [7:0]         mag;
    scaled = MUL_P_W'(p) >> SHIFT;
    sum = {1'b0, scaled[6:0]} + {1'b0, ofs};
    mag = (|scaled[MUL_P_W-1:7] || sum > PCT_LIMIT) ? PCT_LIMIT : sum;
    if (w == '0) begin
      return 8'sd0;
    end
    return w[WHEEL_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign base      = $signed({item.linear_speed, {HT_FRAC{1'b0}}});
  assign comp      = prod[COMP_W-1:0];

  ddcg_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  always_comb begin
    mreq = '0;
    unique case (state)
      S_COMP: begin
        mreq.load = 1'b1;
        mreq.a    = MUL_A_W'(item.angular_speed);
        mreq.b    = half_track;
      end
      S_MULL: begin
        mreq.load = 1'b1;
        mreq.a    = wheel_mag(wheel_l);
        mreq.b    = MUL_B_W'(gain_percent);
      end
      S_MULR: begin
        mreq.load = 1'b1;
        mreq.a    = wheel_mag(wheel_r);
        mreq.b    = MUL_B_W'(gain_percent);
      end
      default: mreq = '0;
    endcase
  end

  always_comb begin
    tgt_l = item.estop ? 8'sd0 : left_target;
    tgt_r = item.estop ? 8'sd0 : right_target;
    priority if (!item.estop && item.action == ACT_CMD) begin
      elapsed_next = '0;
    end else if (item.action == ACT_TICK && elapsed_ms != ELAPSED_MAX) begin
      elapsed_next = elapsed_ms + 1'b1;
    end else begin
      elapsed_next = elapsed_ms;
    end
    priority if (item.estop) begin
      cause = CAUSE_ESTOP;
    end else if (item.front_contact && tgt_l > 0 && tgt_r > 0) begin
      cause = CAUSE_FRONT;
    end else if (item.rear_contact && tgt_l < 0 && tgt_r < 0) begin
      cause = CAUSE_REAR;
    end else if (elapsed_next > {1'b0, timeout_ms}) begin
      cause = CAUSE_TMO;
    end else begin
      cause = CAUSE_NONE;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.estop || in_data.action == ACT_TICK) ? S_GATE : S_COMP;
        end
      end
      S_COMP:  state_next = S_WHEEL;
      S_WHEEL: state_next = S_MULL;
      S_MULL:  state_next = S_MULR;
      S_MULR:  state_next = S_PCTR;
      S_PCTR:  state_next = S_GATE;
      S_GATE:  state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      half_track     <= 12'd819;
      gain_percent   <= 8'd90;
      offset_percent <= 7'd8;
      timeout_ms     <= 16'd1000;
      left_target    <= '0;
      right_target   <= '0;
      elapsed_ms     <= ELAPSED_MAX;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_HALF_TRACK:     half_track     <= cfg_data[HT_W-1:0];
          CFG_GAIN_PERCENT:   gain_percent   <= cfg_data[GAIN_W-1:0];
          CFG_OFFSET_PERCENT: offset_percent <= cfg_data[OFS_W-1:0];
          CFG_TIMEOUT_MS:     timeout_ms     <= cfg_data[TMO_W-1:0];
          default: ;
        endcase
      end
      if (state == S_MULR) begin
        left_target <= wheel_pct(prod, wheel_l, offset_percent);
      end
      if (state == S_PCTR) begin
        right_target <= wheel_pct(prod, wheel_r, offset_percent);
      end
      if (state == S_GATE) begin
        left_target  <= tgt_l;
        right_target <= tgt_r;
        elapsed_ms   <= elapsed_next;
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item <= in_data;
    end
    if (state == S_WHEEL) begin
      wheel_l <= WHEEL_W'(base) - WHEEL_W'(comp);
      wheel_r <= WHEEL_W'(base) + WHEEL_W'(comp);
    end
    if (state == S_GATE) begin
      gate_cause <= cause;
      gate_l     <= (cause == CAUSE_NONE) ? tgt_l : 8'sd0;
      gate_r     <= (cause == CAUSE_NONE) ? tgt_r : 8'sd0;
    end
    if (state == S_EMIT && out_free) begin
      out_data.left_drive    <= map_drive(gate_l);
      out_data.right_drive   <= map_drive(gate_r);
      out_data.left_percent  <= gate_l;
      out_data.right_percent <= gate_r;
      out_data.block_cause   <= gate_cause;
    end
  end

endmodule

>>> bench/differential_drive_command_gate_tb.sv
// Self-checking testbench for the differential drive command gate: scoreboard class and stimulus.
module differential_drive_command_gate_tb
  import ddcg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_FRAC_BITS = 12;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 16;

  class drive_scoreboard;
    logic [HT_W-1:0]      half_track;
    logic [GAIN_W-1:0]    gain_percent;
    logic [OFS_W-1:0]     offset_percent;
    logic [TMO_W-1:0]     timeout_ms;
    int                   left_target;
    int                   right_target;
    logic [ELAPSED_W-1:0] elapsed_ms;
    out_item_t            expected_drive[$];
    int                   errors;
    int                   items_seen;
    int                   results_seen;
    int                   cause_seen[5];

    function new();
      half_track     = 12'd819;
      gain_percent   = 8'd90;
      offset_percent = 7'd8;
      timeout_ms     = 16'd1000;
      left_target    = 0;
      right_target   = 0;
      elapsed_ms     = ELAPSED_MAX;
      errors         = 0;
      items_seen     = 0;
      results_seen   = 0;
      foreach (cause_seen[i]) cause_seen[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      unique case (idx)
        CFG_HALF_TRACK:     half_track = data[HT_W-1:0];
        CFG_GAIN_PERCENT:   gain_percent = data[GAIN_W-1:0];
        CFG_OFFSET_PERCENT: offset_percent = data[OFS_W-1:0];
        CFG_TIMEOUT_MS:     timeout_ms = data[TMO_W-1:0];
        default: ;
      endcase
    endfunction

    // nonzero speed: floor(|w| * gain >> (frac bits + HT_FRAC)) + offset, clamped, sign restored
    function int wheel_percent(longint w);
      longint mag;
      longint pct;
      if (w == 0) return 0;
      mag = (w < 0) ? -w : w;
      pct = ((mag * longint'(gain_percent)) >>> (TB_FRAC_BITS + HT_FRAC))
            + longint'(offset_percent);
      if (pct > 100) pct = 100;
      return (w < 0) ? -int'(pct) : int'(pct);
    endfunction

    function int drive_of(int p);
      return ((p + 100) * 254) / 200 - 127;
    endfunction

    function void note_item(in_item_t it);
      longint     base;
      longint     comp;
      int         lp;
      int         rp;
      logic [2:0] cause;
      out_item_t  exp;
      lp = 0;
      rp = 0;
      items_seen++;
      if (it.estop) begin
        left_target  = 0;
        right_target = 0;
      end else if (it.action == ACT_CMD) begin
        base = longint'($signed(it.linear_speed)) * (longint'(1) <<< HT_FRAC);
        comp = longint'($signed(it.angular_speed)) * longint'(half_track);
        left_target  = wheel_percent(base - comp);
        right_target = wheel_percent(base + comp);
        elapsed_ms   = '0;
      end
      if (it.action == ACT_TICK && elapsed_ms < ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;

      if (it.estop) cause = CAUSE_ESTOP;
      else if (it.front_contact && left_target > 0 && right_target > 0) cause = CAUSE_FRONT;
      else if (it.rear_contact && left_target < 0 && right_target < 0) cause = CAUSE_REAR;
      else if (elapsed_ms > timeout_ms) cause = CAUSE_TMO;
      else begin
        cause = CAUSE_NONE;
        lp    = left_target;
        rp    = right_target;
      end

      exp.left_drive    = 8'(drive_of(lp));
      exp.right_drive   = 8'(drive_of(rp));
      exp.left_percent  = 8'(lp);
      exp.right_percent = 8'(rp);
      exp.block_cause   = cause;
      expected_drive.push_back(exp);
    endfunction

    function void check_item(out_item_t got);
      out_item_t exp;
      bit        bad;
      results_seen++;
      if (expected_drive.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result %0d: drive %0d/%0d percent %0d/%0d cause %0d",
                   results_seen, got.left_drive, got.right_drive, got.left_percent,
                   got.right_percent, got.block_cause);
        return;
      end
      exp = expected_drive.pop_front();
      if (exp.block_cause < 5) cause_seen[exp.block_cause]++;
      bad = (got.left_drive !== exp.left_drive) || (got.right_drive !== exp.right_drive) ||
            (got.left_percent !== exp.left_percent) ||
            (got.right_percent !== exp.right_percent) ||
            (got.block_cause !== exp.block_cause);
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: exp %0d/%0d %0d/%0d cause %0d, got %0d/%0d %0d/%0d cause %0d",
                   results_seen, exp.left_drive, exp.right_drive, exp.left_percent,
                   exp.right_percent, exp.block_cause, got.left_drive, got.right_drive,
                   got.left_percent, got.right_percent, got.block_cause);
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  drive_scoreboard sb;
  int sender_idle;
  int stall_pct;
  int hold_left;

  differential_drive_command_gate #(
    .FRAC_BITS(TB_FRAC_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_item(out_data);
    end
  end

  function automatic in_item_t mk_cmd(int lin, int ang, bit e, bit f, bit r);
    in_item_t it;
    it.action        = ACT_CMD;
    it.linear_speed  = 16'(lin);
    it.angular_speed = 16'(ang);
    it.estop         = e;
    it.front_contact = f;
    it.rear_contact  = r;
    return it;
  endfunction

  function automatic in_item_t mk_tick(bit e, bit f, bit r);
    in_item_t it;
    it = mk_cmd(int'($urandom_range(65535)), int'($urandom_range(65535)), e, f, r);
    it.action = ACT_TICK;
    return it;
  endfunction

  // mostly small speeds so percents land inside the clamp, some full range
  function automatic int rand_speed();
    int sel;
    sel = int'($urandom_range(15));
    if (sel == 0) return 0;
    if (sel < 5) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(12000)) - 6000;
  endfunction

  function automatic in_item_t rand_item();
    bit e;
    bit f;
    bit r;
    e = ($urandom_range(99) < 8);
    f = ($urandom_range(99) < 30);
    r = ($urandom_range(99) < 30);
    if ($urandom_range(99) < 45) return mk_cmd(rand_speed(), rand_speed(), e, f, r);
    return mk_tick(e, f, r);
  endfunction

  task automatic offer_item(input in_item_t it);
    while ($urandom_range(99) < sender_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain_all();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(input int ht, input int gain, input int ofs, input int tmo,
                           input int idle, input int stall, input int count,
                           input int hold_at, input int pause_at);
    drain_all();
    // half track and gain data bits beyond the register width are noise
    write_cfg(CFG_HALF_TRACK, CFG_DAT_W'(ht) | (CFG_DAT_W'($urandom_range(15)) << HT_W));
    write_cfg(CFG_GAIN_PERCENT, CFG_DAT_W'(gain) | (CFG_DAT_W'($urandom_range(255)) << GAIN_W));
    write_cfg(CFG_OFFSET_PERCENT, CFG_DAT_W'(ofs));
    write_cfg(CFG_TIMEOUT_MS, CFG_DAT_W'(tmo));
    sender_idle = idle;
    stall_pct   = stall;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_left = LONG_HOLD;
      if (i == pause_at) drain_all();
      offer_item(rand_item());
    end
    in_valid = 1'b0;
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    sender_idle = 0;
    stall_pct   = 0;
    hold_left   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset defaults: timed out and saturated until the first command
    offer_item(mk_tick(1'b0, 1'b0, 1'b0));
    offer_item(mk_tick(1'b0, 1'b1, 1'b0));
    offer_item(mk_cmd(0, 0, 1'b0, 1'b0, 1'b0));
    offer_item(mk_cmd(4096, 0, 1'b0, 1'b0, 1'b0));
    offer_item(mk_cmd(4096, 0, 1'b0, 1'b1, 1'b0));
    offer_item(mk_cmd(-4096, 0, 1'b0, 1'b0, 1'b1));
    offer_item(mk_cmd(-4096, 0, 1'b0, 1'b1, 1'b0));
    offer_item(mk_cmd(32767, 32767, 1'b0, 1'b0, 1'b0));
    offer_item(mk_cmd(-32768, -32768, 1'b0, 1'b0, 1'b1));
    offer_item(mk_cmd(0, 32767, 1'b0, 1'b1, 1'b1));
    offer_item(mk_cmd(0, -32768, 1'b0, 1'b0, 1'b0));
    offer_item(mk_cmd(1, 0, 1'b0, 1'b0, 1'b0));
    offer_item(mk_cmd(4096, 0, 1'b1, 1'b0, 1'b0));
    offer_item(mk_tick(1'b0, 1'b0, 1'b0));
    offer_item(mk_tick(1'b1, 1'b1, 1'b1));
    offer_item(mk_cmd(32767, 0, 1'b0, 1'b1, 1'b1));
    drain_all();
    write_cfg(CFG_TIMEOUT_MS, CFG_DAT_W'(2));
    offer_item(mk_cmd(2048, 0, 1'b0, 1'b0, 1'b0));
    offer_item(mk_tick(1'b0, 1'b0, 1'b0));
    offer_item(mk_tick(1'b0, 1'b0, 1'b0));
    offer_item(mk_tick(1'b0, 1'b0, 1'b0));
    offer_item(mk_cmd(2048, 1000, 1'b0, 1'b0, 1'b0));

    run_phase(819, 90, 8, 3, 0, 0, 500, -1, -1);
    run_phase(0, 0, 0, 0, 50, 0, 500, -1, 250);
    drain_all();
    write_cfg(CFG_TIMEOUT_MS + 8'd1 + 8'($urandom_range(251)), CFG_DAT_W'($urandom_range(65535)));
    run_phase(4095, 255, 100, 65535, 0, 50, 500, 100, -1);
    run_phase(int'($urandom_range(4095)), int'($urandom_range(255)), int'($urandom_range(100)),
              int'($urandom_range(15)), 37, 37, 500, 300, -1);
    drain_all();

    $display("run covered %0d items and %0d results over five register settings",
             sb.items_seen, sb.results_seen);
    $display("causes: none %0d, estop %0d, front %0d, rear %0d, timeout %0d",
             sb.cause_seen[0], sb.cause_seen[1], sb.cause_seen[2], sb.cause_seen[3],
             sb.cause_seen[4]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
